[sv/bdbm_pkg.sv]
// Package for the bus decoder and bank mapper: codes, address constants and word types.
// Used by the channel interfaces and the top level; depends on nothing.
package bdbm_pkg;

    // Storage sizes. The work RAM depth must be a power of two.
    localparam int RAM_BYTES  = 32768;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int BANK_SLOTS = 8;
    localparam int SLOT_AW    = $clog2(BANK_SLOTS);

    // Access kinds.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Target codes.
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_PPU  = 3'd1;
    localparam logic [2:0] TGT_APU  = 3'd2;
    localparam logic [2:0] TGT_EXP  = 3'd3;
    localparam logic [2:0] TGT_BANK = 3'd4;
    localparam logic [2:0] TGT_CART = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BANK_SIZE     = 2'd0;
    localparam logic [1:0] CFG_POWER_ON_BANK = 2'd1;
    localparam logic [1:0] CFG_EXP_PRESENT   = 2'd2;

    // Address windows.
    localparam logic [15:0] PPU_READ_MASK  = 16'hFFF9;
    localparam logic [15:0] PPU_READ_MATCH = 16'h0211;
    localparam logic [15:0] PPU_WRITE_BASE = 16'h0210;
    localparam logic [15:0] APU_MASK       = 16'hFFE0;
    localparam logic [15:0] APU_BASE       = 16'h0220;
    localparam logic [15:0] APU_OFFSET     = 16'h001F;
    localparam logic [15:0] EXP_MASK       = 16'hFFF8;
    localparam logic [15:0] EXP_BASE       = 16'h0240;
    localparam logic [15:0] REG_MASK       = 16'hFFF0;
    localparam logic [15:0] BANK_REG_BASE  = 16'h0248;
    localparam logic [15:0] DEBUG_PORT     = 16'h0247;
    localparam logic [15:0] IO_LOW         = 16'h0200;
    localparam logic [15:0] IO_END         = 16'h0250;
    localparam logic [15:0] WINDOW_16      = 16'h0010;
    localparam logic [7:0]  MISSING_BYTE   = 8'hBB;

    // One bus access.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        opcode_fetch;
        logic        overlay_line;
        logic        vector_pull;
    } access_t;

    // One decoded result.
    typedef struct packed {
        logic [2:0]  target;
        logic [7:0]  mapped_bank;
        logic [15:0] forward_address;
        logic [7:0]  forward_data;
        logic [7:0]  read_data;
        logic        bad_access;
        logic        forward_overlay;
        logic        forward_vector_pull;
        logic        forward_sync;
    } result_t;

endpackage

[sv/bdbm_if.sv]
// Valid/ready channels for bus accesses and decoded results.
// Depends on bdbm_pkg for the word types.
interface bdbm_access_if;
    logic              valid;
    logic              ready;
    bdbm_pkg::access_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bdbm_result_if;
    logic              valid;
    logic              ready;
    bdbm_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/bdbm_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; no package dependency.
module bdbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register; the output holds when idle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/bus_decoder_bank_mapper.sv]
// Top level of the CPU bus decoder and bank mapper.
// Depends on bdbm_pkg, the channels in bdbm_if and the RAM in bdbm_ram.

// One bus access enters per cycle while the result side keeps up. The access is decoded and
// the work RAM is read or written at the accepting edge; stage one holds the decoded word and
// the RAM output register holds the byte, and the result register takes both when stage one
// moves, which it does only when the result register is empty or being taken; so a new word
// is accepted while a finished result waits only if stage one is empty. Writes below 0x8000
// always store into work RAM; writes to 0x248-0x24F reload an aligned group of bank slots,
// sized by the bank-size register, and the next access already sees the new banks. Writing
// the power-on bank register reloads every slot. Configuration is to be written only while no
// access is in flight. Reading a RAM byte that was never written returns an undefined value.
module bus_decoder_bank_mapper (
    input  logic                  clk,
    input  logic                  rst_n,
    bdbm_access_if.sink           access,
    bdbm_result_if.source         result,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    typedef struct packed {
        bdbm_pkg::result_t res;
        logic              use_ram;
    } stage_t;

    // Configuration registers.
    logic [1:0] bank_size_reg;
    logic [7:0] exp_present_reg;

    // Bank slots.
    logic [7:0] slot_reg [bdbm_pkg::BANK_SLOTS];

    // Pipeline registers.
    logic   s1_valid_reg;
    stage_t s1_reg;
    logic   s2_valid_reg;
    bdbm_pkg::result_t s2_reg;

    // Handshake and decode signals.
    logic                          acc_fire;
    logic                          s1_move;
    stage_t                        dec;
    logic                          ram_we;
    logic                          bank_we;
    logic [15:0]                   addr;
    logic [bdbm_pkg::SLOT_AW-1:0]  port;
    logic [bdbm_pkg::SLOT_AW-1:0]  span;
    logic [7:0]                    cur_bank;
    logic [7:0]                    ram_rdata;
    bdbm_pkg::result_t             s2_next;

    assign s1_move      = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign access.ready = !s1_valid_reg || s1_move;
    assign acc_fire     = access.valid && access.ready;

    assign addr     = access.data.address;
    assign port     = addr[bdbm_pkg::SLOT_AW-1:0];
    assign span     = {bdbm_pkg::SLOT_AW{1'b1}} >> bank_size_reg;
    assign cur_bank = slot_reg[addr[bdbm_pkg::SLOT_AW+11:12]];

    // Decode of one access word.
    always_comb
    begin
        dec     = '0;
        ram_we  = 1'b0;
        bank_we = 1'b0;
        unique case (access.data.kind)
            bdbm_pkg::KIND_READ:
            begin
                dec.res.forward_address = addr;
                if (!addr[15])
                begin
                    if ((addr & bdbm_pkg::PPU_READ_MASK) == bdbm_pkg::PPU_READ_MATCH)
                    begin
                        dec.res.target = bdbm_pkg::TGT_PPU;
                    end
                    else if ((addr & bdbm_pkg::EXP_MASK) == bdbm_pkg::EXP_BASE)
                    begin
                        dec.res.target = bdbm_pkg::TGT_EXP;
                        if (!exp_present_reg[port])
                        begin
                            dec.res.read_data  = bdbm_pkg::MISSING_BYTE;
                            dec.res.bad_access = (addr != bdbm_pkg::DEBUG_PORT);
                        end
                    end
                    else
                    begin
                        dec.use_ram = 1'b1;
                    end
                end
                else
                begin
                    dec.res.target              = bdbm_pkg::TGT_CART;
                    dec.res.mapped_bank         = cur_bank;
                    dec.res.forward_overlay     = access.data.overlay_line;
                    dec.res.forward_vector_pull = access.data.vector_pull;
                    dec.res.forward_sync        = access.data.opcode_fetch;
                end
            end
            bdbm_pkg::KIND_WRITE:
            begin
                dec.res.forward_address = addr;
                dec.res.forward_data    = access.data.write_data;
                if (!addr[15])
                begin
                    ram_we = 1'b1;
                    if (addr >= bdbm_pkg::IO_LOW && addr < bdbm_pkg::IO_END)
                    begin
                        if ((addr ^ bdbm_pkg::PPU_WRITE_BASE) < bdbm_pkg::WINDOW_16)
                        begin
                            dec.res.target = bdbm_pkg::TGT_PPU;
                        end
                        else if ((addr & bdbm_pkg::APU_MASK) == bdbm_pkg::APU_BASE)
                        begin
                            dec.res.target          = bdbm_pkg::TGT_APU;
                            dec.res.forward_address = addr & bdbm_pkg::APU_OFFSET;
                        end
                        else if ((addr & bdbm_pkg::REG_MASK) == bdbm_pkg::EXP_BASE)
                        begin
                            if (addr >= bdbm_pkg::BANK_REG_BASE)
                            begin
                                dec.res.target = bdbm_pkg::TGT_BANK;
                                bank_we        = 1'b1;
                            end
                            else
                            begin
                                dec.res.target = bdbm_pkg::TGT_EXP;
                                if (!exp_present_reg[port])
                                begin
                                    dec.res.bad_access = (addr != bdbm_pkg::DEBUG_PORT);
                                end
                            end
                        end
                    end
                end
                else
                begin
                    dec.res.target      = bdbm_pkg::TGT_CART;
                    dec.res.mapped_bank = cur_bank;
                end
            end
            bdbm_pkg::KIND_QUERY:
            begin
                if (addr[15])
                begin
                    dec.res.target      = bdbm_pkg::TGT_CART;
                    dec.res.mapped_bank = cur_bank;
                end
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    // Work RAM, accessed at the accepting edge.
    bdbm_ram #(
        .WIDTH (8),
        .DEPTH (bdbm_pkg::RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .en    (acc_fire && (dec.use_ram || ram_we)),
        .we    (ram_we),
        .addr  (addr[bdbm_pkg::RAM_AW-1:0]),
        .wdata (access.data.write_data),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_size_reg   <= '0;
            exp_present_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bdbm_pkg::CFG_BANK_SIZE:   bank_size_reg   <= cfg_data[1:0];
                bdbm_pkg::CFG_EXP_PRESENT: exp_present_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Bank slots: reloaded from the power-on bank, or an aligned group filled by a bank write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < bdbm_pkg::BANK_SLOTS; n++)
            begin
                slot_reg[bdbm_pkg::SLOT_AW'(n)] <= '0;
            end
        end
        else if (cfg_write && cfg_index == bdbm_pkg::CFG_POWER_ON_BANK)
        begin
            for (int n = 0; n < bdbm_pkg::BANK_SLOTS; n++)
            begin
                slot_reg[bdbm_pkg::SLOT_AW'(n)] <= cfg_data;
            end
        end
        else if (acc_fire && bank_we)
        begin
            for (int n = 0; n < bdbm_pkg::BANK_SLOTS; n++)
            begin
                if ((bdbm_pkg::SLOT_AW'(n) | span) == (port | span))
                begin
                    slot_reg[bdbm_pkg::SLOT_AW'(n)] <= access.data.write_data;
                end
            end
        end
    end

    // Stage one: decoded word waiting for the RAM byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            s1_valid_reg <= access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire)
        begin
            s1_reg <= dec;
        end
    end

    // Merge the RAM byte into the result.
    always_comb
    begin
        s2_next = s1_reg.res;
        if (s1_reg.use_ram)
        begin
            s2_next.read_data = ram_rdata;
        end
    end

    // Stage two: result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
    end

    assign result.valid = s2_valid_reg;
    assign result.data  = s2_reg;

    // A bad access only ever comes from the expansion window.
    a_bad_is_exp: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.bad_access |-> result.data.target == bdbm_pkg::TGT_EXP)
        else $error("bad_access set on a target other than expansion");

    // A non-zero bank is only reported for cartridge accesses.
    a_bank_is_cart: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.mapped_bank != 8'd0
        |-> result.data.target == bdbm_pkg::TGT_CART)
        else $error("mapped_bank set on a non-cartridge result");

    // A word leaving stage one always shows up in the result register.
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> s2_valid_reg)
        else $error("word lost between stage one and the result register");

endmodule
